[rtl/crc_feedback_nibble_cipher_top_assert.svh]
// assertion macros for the cipher rtl, used by cfnc_queue
// expects clk and rst_n in the scope where a macro is used
`ifndef CRC_FEEDBACK_NIBBLE_CIPHER_TOP_ASSERT_SVH
`define CRC_FEEDBACK_NIBBLE_CIPHER_TOP_ASSERT_SVH

// same-cycle implication
`define CFNC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CFNC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cfnc_pkg.sv]
// types and constants for the crc feedback nibble cipher
// no dependencies
`timescale 1ns / 1ps

package cfnc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_SEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd1;

    localparam logic [1:0] MODE_ENCRYPT  = 2'd0;
    localparam logic [1:0] MODE_DECRYPT  = 2'd1;
    localparam logic [1:0] MODE_CHECKSUM = 2'd2;

    // classified item handed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
        logic       last;
        logic       decrypt;
        logic       emit;
    } cmd_t;

endpackage

[rtl/crc_feedback_nibble_cipher_top.sv]
// path: an accepted item passes the front register, a queue slot and the output
//   register, in that order, before it shows on the output
// throughput: one item per cycle if no side stalls, set by the two-nibble crc update
//   in the back stage; front stage, queue and output register let each side stall
// reset: crc register, key seed and mode clear to zero (encrypt), queue empties
// top level of the crc feedback nibble cipher
// depends on cfnc_pkg, cfnc_front, cfnc_queue, cfnc_back
`timescale 1ns / 1ps

module crc_feedback_nibble_cipher_top
    import cfnc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    input  logic                  first_in,
    input  logic                  last_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic [15:0]           crc_state,
    output logic                  last_out
);

    logic [15:0] key_seed_reg;
    logic [1:0]  mode_reg;
    logic        push_valid;
    logic        push_ready;
    cmd_t        push_item;
    logic        pop_valid;
    logic        pop_ready;
    cmd_t        pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_seed_reg <= '0;
            mode_reg     <= MODE_ENCRYPT;
        end
        else if (cfg_we)
        begin
            // indexes past the register list are dropped
            if (cfg_index == REG_KEY_SEED)
            begin
                key_seed_reg <= cfg_data[15:0];
            end
            else if (cfg_index == REG_MODE)
            begin
                mode_reg <= cfg_data[1:0];
            end
        end
    end

    cfnc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .first_in   (first_in),
        .last_in    (last_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    cfnc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    cfnc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_seed  (key_seed_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .crc_state (crc_state),
        .last_out  (last_out)
    );

endmodule

[rtl/cfnc_front.sv]
// front stage: accepts input items and classifies them by mode
// depends on cfnc_pkg
`timescale 1ns / 1ps

module cfnc_front
    import cfnc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] mode,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       first_in,
    input  logic       last_in,
    output logic       push_valid,
    input  logic       push_ready,
    output cmd_t       push_item
);

    logic f_valid_reg;
    logic f_valid_next;
    cmd_t f_item_reg;
    cmd_t f_item_next;
    logic take;

    assign in_ready = !f_valid_reg || push_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        f_item_next           = f_item_reg;
        f_item_next.data_byte = data_byte;
        f_item_next.first     = first_in;
        f_item_next.last      = last_in;
        unique case (mode)
            MODE_ENCRYPT:
            begin
                f_item_next.decrypt = 1'b0;
                f_item_next.emit    = 1'b1;
            end
            MODE_DECRYPT:
            begin
                f_item_next.decrypt = 1'b1;
                f_item_next.emit    = 1'b1;
            end
            default:
            begin
                // checksum and the unused code: register as in encrypt, byte zeroed
                f_item_next.decrypt = 1'b0;
                f_item_next.emit    = 1'b0;
            end
        endcase
    end

    assign f_valid_next = take || (f_valid_reg && !push_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            f_item_reg <= f_item_next;
        end
    end

    assign push_valid = f_valid_reg;
    assign push_item  = f_item_reg;

endmodule

[rtl/cfnc_queue.sv]
// short fifo between the front and back stages
// depends on cfnc_pkg and the assertion macro header
`timescale 1ns / 1ps

`include "crc_feedback_nibble_cipher_top_assert.svh"

module cfnc_queue
    import cfnc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_item,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

    `CFNC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= FULL_CNT, "queue count beyond depth")
    `CFNC_ASSERT_NOW(a_no_pop_empty, pop, count_reg != '0, "pop from empty queue")
    `CFNC_ASSERT_NEXT(a_push_grows, push && !pop, count_reg == $past(count_reg) + 1'b1, "push lost")
    `CFNC_ASSERT_NEXT(a_pop_shrinks, pop && !push, count_reg == $past(count_reg) - 1'b1, "pop lost")

endmodule

[rtl/cfnc_back.sv]
// back stage: two nibble crc steps per item and the output register
// depends on cfnc_pkg
`timescale 1ns / 1ps

module cfnc_back
    import cfnc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] key_seed,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  cmd_t        pop_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic [15:0] crc_state,
    output logic        last_out
);

    // fed * 0x1081 for a nibble: the three shifted copies never overlap
    function automatic logic [15:0] poly_term(input logic [3:0] fed);
        poly_term = {fed, 12'b0} ^ {5'b0, fed, 7'b0} ^ {12'b0, fed};
    endfunction

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic [7:0]  out_byte_next;
    logic [15:0] crc_state_reg;
    logic        last_out_reg;
    logic        pop;
    logic [15:0] start;
    logic [15:0] mid;
    logic [3:0]  lo;
    logic [3:0]  hi;
    logic [3:0]  fed_lo;
    logic [3:0]  fed_hi;

    assign pop_ready = !out_valid_reg || out_ready;
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        start    = pop_item.first ? key_seed : crc_reg;
        lo       = start[3:0] ^ pop_item.data_byte[3:0];
        fed_lo   = pop_item.decrypt ? pop_item.data_byte[3:0] : lo;
        mid      = {4'b0, start[15:4]} ^ poly_term(fed_lo);
        hi       = mid[3:0] ^ pop_item.data_byte[7:4];
        fed_hi   = pop_item.decrypt ? pop_item.data_byte[7:4] : hi;
        crc_next = {4'b0, mid[15:4]} ^ poly_term(fed_hi);
        out_byte_next = pop_item.emit ? {hi, lo} : 8'h00;
    end

    assign out_valid_next = pop || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                crc_reg <= crc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_byte_reg  <= out_byte_next;
            crc_state_reg <= crc_next;
            last_out_reg  <= pop_item.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign crc_state = crc_state_reg;
    assign last_out  = last_out_reg;

endmodule

[sim/tb_top.sv]
// self-checking testbench for crc_feedback_nibble_cipher_top: directed and random byte streams
// with random stalls on both sides, checked against a cycle-free predictor of the nibble cipher
// depends on cfnc_pkg and the cipher rtl
`timescale 1ns / 1ps

module tb_top;
    import cfnc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B   = 2'd3;
    localparam logic [1:0]           MODE_RESERVED = 2'd3;
    localparam logic [15:0]          CRC_NIBBLE_POLY = 16'h1081;
    localparam int                   STALL_LIMIT = 2000;

    typedef struct {
        logic [7:0]  out_byte;
        logic [15:0] crc_state;
        logic        last_out;
    } cipher_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [7:0]            data_byte = '0;
    logic                  first_in = 1'b0;
    logic                  last_in = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [7:0]            out_byte;
    logic [15:0]           crc_state;
    logic                  last_out;

    // predictor copy of the block state
    logic [15:0] crc_reg = '0;
    logic [15:0] seed_reg = '0;
    logic [1:0]  mode_reg = MODE_ENCRYPT;

    cipher_result_t pending_results[$];
    bit pauses_on = 1'b1;
    int fail_count = 0;
    int bytes_sent = 0;
    int results_checked = 0;
    int messages_sent = 0;
    int reg_writes = 0;
    int quiet_cycles = 0;

    crc_feedback_nibble_cipher_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .first_in  (first_in),
        .last_in   (last_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .crc_state (crc_state),
        .last_out  (last_out)
    );

    always #4 clk = ~clk;

    // advances the crc register over one byte, low nibble first
    function automatic cipher_result_t cipher_advance(input logic [7:0] b, input logic first,
                                                      input logic last);
        cipher_result_t r;
        logic [3:0] nib;
        logic [3:0] ct;
        logic [3:0] fed;
        logic [7:0] ob;
        logic       decrypt;
        logic       emit;
        decrypt = (mode_reg == MODE_DECRYPT);
        emit = (mode_reg == MODE_ENCRYPT) || decrypt;
        if (first)
            crc_reg = seed_reg;
        for (int k = 0; k < 2; k++)
        begin
            nib = b[4*k +: 4];
            ct = crc_reg[3:0] ^ nib;
            fed = decrypt ? nib : ct;
            crc_reg = (crc_reg >> 4) ^ ({12'd0, fed} * CRC_NIBBLE_POLY);
            ob[4*k +: 4] = ct;
        end
        r.out_byte = emit ? ob : 8'h00;
        r.crc_state = crc_reg;
        r.last_out = last;
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        while (pauses_on && $urandom_range(0, 99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        first_in <= first;
        last_in <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(cipher_advance(b, first, last));
        bytes_sent++;
    endtask

    // drop valid and let every pending item drain before touching registers
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_KEY_SEED)
            seed_reg = value;
        else if (idx == REG_MODE)
            mode_reg = value[1:0];
        reg_writes++;
    endtask

    // reset values, register continues from zero without a first flag
    task automatic test_after_reset();
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hA5, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        messages_sent++;
    endtask

    task automatic test_encrypt_extremes();
        write_reg(REG_KEY_SEED, 16'hFFFF);
        write_reg(REG_MODE, {14'd0, MODE_ENCRYPT});
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h0F, 1'b0, 1'b0);
        send_byte(8'hF0, 1'b0, 1'b1);
        // single-byte message
        send_byte(8'h5A, 1'b1, 1'b1);
        messages_sent += 2;
    endtask

    task automatic test_decrypt_extremes();
        write_reg(REG_KEY_SEED, 16'h0000);
        // upper bits of the mode write are dropped
        write_reg(REG_MODE, {14'h3FFF, MODE_DECRYPT});
        send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h81, 1'b0, 1'b1);
        messages_sent++;
    endtask

    task automatic test_checksum_and_reserved_mode();
        write_reg(REG_KEY_SEED, 16'h1D0F);
        write_reg(REG_MODE, {14'd0, MODE_CHECKSUM});
        send_byte(8'h31, 1'b1, 1'b0);
        send_byte(8'h32, 1'b0, 1'b0);
        send_byte(8'h33, 1'b0, 1'b1);
        // reserved mode behaves like checksum
        write_reg(REG_MODE, {14'd0, MODE_RESERVED});
        send_byte(8'hC3, 1'b1, 1'b0);
        send_byte(8'h3C, 1'b0, 1'b1);
        messages_sent += 2;
    endtask

    task automatic test_unused_indexes();
        write_reg(REG_MODE, {14'd0, MODE_ENCRYPT});
        write_reg(REG_SPARE_A, 16'hFFFF);
        write_reg(REG_SPARE_B, 16'hFFFF);
        send_byte(8'h77, 1'b1, 1'b1);
        send_byte(8'h88, 1'b0, 1'b1);
        messages_sent += 2;
    endtask

    // mostly framed messages with random content, some unframed noise
    task automatic test_random_phase(input logic [1:0] mode_sel, input logic [15:0] seed,
                                     input bit pauses, input int n_items);
        int sent;
        int len;
        bit noisy;
        sent = 0;
        write_reg(REG_KEY_SEED, seed);
        write_reg(REG_MODE, {14'($urandom), mode_sel});
        pauses_on = pauses;
        while (sent < n_items)
        begin
            noisy = ($urandom_range(0, 99) < 20);
            len = noisy ? $urandom_range(1, 8) : $urandom_range(1, 16);
            for (int k = 0; k < len; k++)
            begin
                if (noisy)
                    send_byte(8'($urandom), 1'($urandom), 1'($urandom));
                else
                    send_byte(8'($urandom), k == 0, k == len - 1);
            end
            sent += len;
            messages_sent++;
        end
        pauses_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        cipher_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no item pending: out_byte %02h crc_state %04h",
                           out_byte, crc_state);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_byte !== want.out_byte)
                    begin
                        $error("out_byte expected %02h got %02h", want.out_byte, out_byte);
                        fail_count++;
                    end
                    if (crc_state !== want.crc_state)
                    begin
                        $error("crc_state expected %04h got %04h", want.crc_state, crc_state);
                        fail_count++;
                    end
                    if (last_out !== want.last_out)
                    begin
                        $error("last_out expected %0b got %0b", want.last_out, last_out);
                        fail_count++;
                    end
                    results_checked++;
                end
            end
            out_ready <= !(pauses_on && $urandom_range(0, 99) < 8);
        end
    end

    // ends the run if neither side moves an item for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[crc_feedback_nibble_cipher_top] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_encrypt_extremes();
        test_decrypt_extremes();
        test_checksum_and_reserved_mode();
        test_unused_indexes();

        test_random_phase(MODE_ENCRYPT,  16'($urandom), 1'b1, 145);
        test_random_phase(MODE_DECRYPT,  16'($urandom), 1'b1, 145);
        test_random_phase(MODE_CHECKSUM, 16'($urandom), 1'b1, 145);
        test_random_phase(MODE_RESERVED, 16'($urandom), 1'b1, 140);
        test_random_phase(MODE_ENCRYPT,  16'h0000,      1'b1, 145);
        test_random_phase(MODE_DECRYPT,  16'hFFFF,      1'b1, 145);
        test_random_phase(MODE_ENCRYPT,  16'($urandom), 1'b0, 145);
        test_random_phase(MODE_DECRYPT,  16'($urandom), 1'b0, 145);

        wait_idle();
        repeat (8) @(posedge clk);

        $display("run covered %0d bytes in %0d messages across %0d register writes",
                 bytes_sent, messages_sent, reg_writes);
        $display("%0d results compared, %0d mismatches", results_checked, fail_count);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("[crc_feedback_nibble_cipher_top] OK");
        else
            $display("[crc_feedback_nibble_cipher_top] ERROR");
        $finish;
    end

endmodule
